// File: design/ssd_pkg.sv
package ssd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CRD_W     = 32;
    localparam int DIF_W     = CRD_W + 1;
    localparam int PRD_W     = 2 * DIF_W;
    localparam int SUM_W     = PRD_W + 2;
    localparam int DOT_W     = SUM_W - FRAC_BITS;
    localparam int HALF      = (DOT_W + 1) / 2;
    localparam int HI_W      = DOT_W - HALF;
    localparam int PP_W      = 2 * HALF + 2;
    localparam int WIDE_W    = 2 * DOT_W + 4;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int DIV_STEPS = FRAC_BITS + 1;
    localparam int KP_W      = Q_W + DIF_W + 1;
    localparam int ROOT_W    = CRD_W + 1;
    localparam int SQ_W      = 2 * ROOT_W;
    localparam int PAR_W     = 17;
    localparam int DIST_W    = 33;
    localparam int THR_W     = 32;

    typedef logic signed [CRD_W-1:0]  crd_t;
    typedef logic signed [DIF_W-1:0]  dif_t;
    typedef logic signed [PRD_W-1:0]  prd_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [DOT_W-1:0]  dot_t;
    typedef logic signed [PP_W-1:0]   pp_t;
    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic signed [KP_W-1:0]   kp_t;

    localparam wide_t WIDE_ONE = wide_t'(1) <<< FRAC_BITS;

    typedef struct packed {
        crd_t a0_x;
        crd_t a0_y;
        crd_t a0_z;
        crd_t a1_x;
        crd_t a1_y;
        crd_t a1_z;
        crd_t b0_x;
        crd_t b0_y;
        crd_t b0_z;
        crd_t b1_x;
        crd_t b1_y;
        crd_t b1_z;
    } in_word_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [PAR_W-1:0]  s_param;
        logic [PAR_W-1:0]  t_param;
        crd_t              near_a_x;
        crd_t              near_a_y;
        crd_t              near_a_z;
        crd_t              near_b_x;
        crd_t              near_b_y;
        crd_t              near_b_z;
    } out_word_t;

    // partial products of one wide signed multiply
    typedef struct packed {
        pp_t ll;
        pp_t lh;
        pp_t hl;
        pp_t hh;
    } part_t;

    typedef struct packed {
        logic [WIDE_W-1:0] num;
        logic [WIDE_W-1:0] den;
        logic              zero;
        logic              full;
    } div_in_t;

    typedef struct {
        crd_t a0 [3];
        crd_t b0 [3];
        dif_t u  [3];
        dif_t v  [3];
    } geom_t;

    typedef struct {
        logic [Q_W-1:0] s;
        logic [Q_W-1:0] t;
        crd_t           na [3];
        crd_t           nb [3];
    } side_t;

    function automatic part_t wmul_parts(input dot_t x, input dot_t y);
        logic signed [HALF:0]   xl;
        logic signed [HALF:0]   yl;
        logic signed [HI_W-1:0] xh;
        logic signed [HI_W-1:0] yh;
        part_t                  p;
        xl = $signed({1'b0, x[HALF-1:0]});
        yl = $signed({1'b0, y[HALF-1:0]});
        xh = x[DOT_W-1:HALF];
        yh = y[DOT_W-1:HALF];
        p.ll = pp_t'(xl) * pp_t'(yl);
        p.lh = pp_t'(xl) * pp_t'(yh);
        p.hl = pp_t'(xh) * pp_t'(yl);
        p.hh = pp_t'(xh) * pp_t'(yh);
        return p;
    endfunction

    function automatic wide_t wmul_sum(input part_t p);
        return (wide_t'(p.hh) <<< (2 * HALF))
            + ((wide_t'(p.hl) + wide_t'(p.lh)) <<< HALF)
            + wide_t'(p.ll);
    endfunction

endpackage

// File: design/ssd_ifs.sv
interface ssd_in_if;
    import ssd_pkg::*;
    logic     valid;
    logic     ready;
    in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ssd_out_if;
    import ssd_pkg::*;
    logic      valid;
    logic      ready;
    out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/ssd_div.sv
module ssd_div
    import ssd_pkg::*;
(
    input  logic           clk,
    input  logic           en,
    input  div_in_t        din,
    output logic [Q_W-1:0] q
);

    // one quotient bit per stage, restoring
    logic [WIDE_W:0]   rem_reg  [DIV_STEPS];
    logic [WIDE_W-1:0] den_reg  [DIV_STEPS];
    logic [Q_W-1:0]    q_reg    [DIV_STEPS];
    logic              zero_reg [DIV_STEPS];
    logic              full_reg [DIV_STEPS];

    logic [WIDE_W:0]   rem_next [DIV_STEPS];
    logic [Q_W-1:0]    q_next   [DIV_STEPS];

    always_comb
    begin
        logic [WIDE_W:0]   r;
        logic [WIDE_W-1:0] d;
        logic [Q_W-1:0]    qq;
        logic              ge;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            if (i == 0)
            begin
                r  = {1'b0, din.num};
                d  = din.den;
                qq = '0;
            end
            else
            begin
                r  = rem_reg[i-1];
                d  = den_reg[i-1];
                qq = q_reg[i-1];
            end
            ge = (r >= {1'b0, d});
            rem_next[i] = (ge ? (r - {1'b0, d}) : r) << 1;
            q_next[i]   = {qq[Q_W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rem_next[0];
            q_reg[0]    <= q_next[0];
            den_reg[0]  <= din.den;
            zero_reg[0] <= din.zero;
            full_reg[0] <= din.full;
            for (int i = 1; i < DIV_STEPS; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                q_reg[i]    <= q_next[i];
                den_reg[i]  <= den_reg[i-1];
                zero_reg[i] <= zero_reg[i-1];
                full_reg[i] <= full_reg[i-1];
            end
        end
    end

    always_comb
    begin
        priority if (zero_reg[DIV_STEPS-1])
            q = '0;
        else if (full_reg[DIV_STEPS-1])
            q = Q_W'(1) << FRAC_BITS;
        else
            q = q_reg[DIV_STEPS-1];
    end

endmodule

// File: design/ssd_sqrt.sv
module ssd_sqrt
    import ssd_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [SQ_W-1:0]   sq,
    output logic [ROOT_W-1:0] root
);

    localparam int EXT_W = SQ_W + 1;

    // one root bit per stage, remainder form
    logic [SQ_W-1:0]   rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [SQ_W-1:0]   rem_next  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];

    always_comb
    begin
        logic [SQ_W-1:0]   r;
        logic [ROOT_W-1:0] rt;
        logic [EXT_W-1:0]  trial;
        int                b;
        for (int i = 0; i < ROOT_W; i++)
        begin
            b = ROOT_W - 1 - i;
            if (i == 0)
            begin
                r  = sq;
                rt = '0;
            end
            else
            begin
                r  = rem_reg[i-1];
                rt = root_reg[i-1];
            end
            trial = (EXT_W'(rt) << (b + 1)) | (EXT_W'(1) << (2 * b));
            if ({1'b0, r} >= trial)
            begin
                rem_next[i]  = SQ_W'({1'b0, r} - trial);
                root_next[i] = rt | (ROOT_W'(1) << b);
            end
            else
            begin
                rem_next[i]  = r;
                root_next[i] = rt;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < ROOT_W; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

// File: design/segment_segment_distance_3d.sv
// segment to segment closest approach in 3d, fixed point
//
// in_ch takes one word per pair: end points a0,a1 of the first segment and
// b0,b1 of the second, signed q16.16. out_ch gives one word per pair: the
// distance (unsigned q17.16), both parameters (q1.16) and both closest points.
// cfg_we/cfg_data write the near-zero threshold; stages 6 to 9 read the live
// value, so write it only while no pair is in the pipeline.
//
// the pipeline has 64 register stages: 9 for differences, dot products,
// determinant and clamping, 17 for the two parameter dividers (one quotient
// bit each), 4 for interpolation and squaring and 33 for the root (one bit
// each), then the output register. one word enters and one leaves every
// cycle when out_ch is not stalled.
//
// reset clears all valid bits and sets the threshold to 1. while the output
// word waits, the whole pipeline holds and in_ch.ready is low; nothing is
// dropped or repeated.
module segment_segment_distance_3d
    import ssd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    ssd_in_if.sink           in_ch,
    ssd_out_if.source        out_ch,
    input  logic             cfg_we,
    input  logic [THR_W-1:0] cfg_data
);

    localparam int FRONT = 9 + DIV_STEPS;

    logic [THR_W-1:0] thr_reg;
    wide_t            thr_w;
    logic             en;

    logic             vf_reg [FRONT];
    geom_t            geom_reg [FRONT];
    logic             vl_reg [4];
    logic             vb_reg [ROOT_W];
    side_t            side_reg [ROOT_W];

    logic             out_valid_reg;
    out_word_t        out_reg;

    geom_t            geom_in;

    // front stages
    dif_t  w1_reg [3];
    prd_t  uu2_reg [3], uv2_reg [3], vv2_reg [3], uw2_reg [3], vw2_reg [3];
    dot_t  a3_reg, b3_reg, c3_reg, d3_reg, e3_reg;
    part_t pac4_reg, pbb4_reg, pbe4_reg, pcd4_reg, pae4_reg, pbd4_reg;
    dot_t  a4_reg, b4_reg, c4_reg, d4_reg, e4_reg;
    wide_t pac5_reg, pbb5_reg, pbe5_reg, pcd5_reg, pae5_reg, pbd5_reg;
    dot_t  a5_reg, b5_reg, c5_reg, d5_reg, e5_reg;
    wide_t det6_reg, sn6_reg, tn6_reg, epb6_reg, nd6_reg, bmd6_reg;
    wide_t a6_reg, c6_reg, e6_reg;
    wide_t sn7_reg, sd7_reg, tn7_reg, td7_reg, nd7_reg, bmd7_reg, a7_reg;
    logic  nd_neg7_reg, a_lt_nd7_reg, bmd_neg7_reg, a_lt_bmd7_reg;
    wide_t sn8_reg, sd8_reg, tn8_reg, td8_reg;
    div_in_t sdiv9_reg, tdiv9_reg;

    wide_t sn7_next, sd7_next, tn7_next, td7_next;
    wide_t sn8_next, sd8_next, tn8_next, td8_next;
    div_in_t sdiv9_next, tdiv9_next;

    // back stages
    logic [Q_W-1:0] s_q, t_q;
    logic [Q_W-1:0] s_l1_reg, t_l1_reg, s_l2_reg, t_l2_reg;
    kp_t   ku_l1_reg [3], kv_l1_reg [3];
    crd_t  a0_l1_reg [3], b0_l1_reg [3];
    crd_t  na_l2_reg [3], nb_l2_reg [3];
    dif_t  dp_l2_reg [3];
    crd_t  na_l2_next [3], nb_l2_next [3];
    dif_t  dp_l2_next [3];
    prd_t  sqp_l3_reg [3];
    side_t side_l3_reg, side_l4_reg;
    logic [SQ_W-1:0]   sq_l4_reg;
    logic [ROOT_W-1:0] root;

    // whole pipeline moves unless a finished word is held
    assign en           = !out_valid_reg || out_ch.ready;
    assign in_ch.ready  = en;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;
    assign thr_w        = wide_t'($signed({1'b0, thr_reg}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_W'(1);
        else if (cfg_we)
            thr_reg <= cfg_data;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRONT; i++)
                vf_reg[i] <= 1'b0;
            for (int i = 0; i < 4; i++)
                vl_reg[i] <= 1'b0;
            for (int i = 0; i < ROOT_W; i++)
                vb_reg[i] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vf_reg[0] <= in_ch.valid;
            for (int i = 1; i < FRONT; i++)
                vf_reg[i] <= vf_reg[i-1];
            vl_reg[0] <= vf_reg[FRONT-1];
            for (int i = 1; i < 4; i++)
                vl_reg[i] <= vl_reg[i-1];
            vb_reg[0] <= vl_reg[3];
            for (int i = 1; i < ROOT_W; i++)
                vb_reg[i] <= vb_reg[i-1];
            out_valid_reg <= vb_reg[ROOT_W-1];
        end
    end

    always_comb
    begin
        geom_in.a0[0] = in_ch.data.a0_x;
        geom_in.a0[1] = in_ch.data.a0_y;
        geom_in.a0[2] = in_ch.data.a0_z;
        geom_in.b0[0] = in_ch.data.b0_x;
        geom_in.b0[1] = in_ch.data.b0_y;
        geom_in.b0[2] = in_ch.data.b0_z;
        geom_in.u[0]  = dif_t'(in_ch.data.a1_x) - dif_t'(in_ch.data.a0_x);
        geom_in.u[1]  = dif_t'(in_ch.data.a1_y) - dif_t'(in_ch.data.a0_y);
        geom_in.u[2]  = dif_t'(in_ch.data.a1_z) - dif_t'(in_ch.data.a0_z);
        geom_in.v[0]  = dif_t'(in_ch.data.b1_x) - dif_t'(in_ch.data.b0_x);
        geom_in.v[1]  = dif_t'(in_ch.data.b1_y) - dif_t'(in_ch.data.b0_y);
        geom_in.v[2]  = dif_t'(in_ch.data.b1_z) - dif_t'(in_ch.data.b0_z);
    end

    // first branch: parallel fallback, then clamp of s against 0 and 1
    always_comb
    begin
        priority if (det6_reg < thr_w)
        begin
            sn7_next = '0;
            sd7_next = WIDE_ONE;
            tn7_next = e6_reg;
            td7_next = c6_reg;
        end
        else if (sn6_reg < 0)
        begin
            sn7_next = '0;
            sd7_next = det6_reg;
            tn7_next = e6_reg;
            td7_next = c6_reg;
        end
        else if (det6_reg < sn6_reg)
        begin
            sn7_next = det6_reg;
            sd7_next = det6_reg;
            tn7_next = epb6_reg;
            td7_next = c6_reg;
        end
        else
        begin
            sn7_next = sn6_reg;
            sd7_next = det6_reg;
            tn7_next = tn6_reg;
            td7_next = det6_reg;
        end
    end

    // clamp of t, s worked out again on that edge
    always_comb
    begin
        sn8_next = sn7_reg;
        sd8_next = sd7_reg;
        tn8_next = tn7_reg;
        td8_next = td7_reg;
        priority if (tn7_reg < 0)
        begin
            tn8_next = '0;
            priority if (nd_neg7_reg)
                sn8_next = '0;
            else if (a_lt_nd7_reg)
                sn8_next = sd7_reg;
            else
            begin
                sn8_next = nd7_reg;
                sd8_next = a7_reg;
            end
        end
        else if (td7_reg < tn7_reg)
        begin
            tn8_next = td7_reg;
            priority if (bmd_neg7_reg)
                sn8_next = '0;
            else if (a_lt_bmd7_reg)
                sn8_next = sd7_reg;
            else
            begin
                sn8_next = bmd7_reg;
                sd8_next = a7_reg;
            end
        end
        else
        begin
            sn8_next = sn7_reg;
        end
    end

    // divider setup: near-zero or negative numerator or non-positive denominator gives 0, over-range gives 1
    always_comb
    begin
        sdiv9_next.num  = sn8_reg;
        sdiv9_next.den  = sd8_reg;
        sdiv9_next.zero = (sn8_reg < thr_w) || (sn8_reg < 0) || !(sd8_reg > 0);
        sdiv9_next.full = sd8_reg < sn8_reg;
        tdiv9_next.num  = tn8_reg;
        tdiv9_next.den  = td8_reg;
        tdiv9_next.zero = (tn8_reg < thr_w) || (tn8_reg < 0) || !(td8_reg > 0);
        tdiv9_next.full = td8_reg < tn8_reg;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            na_l2_next[i] = a0_l1_reg[i] + crd_t'(ku_l1_reg[i] >>> FRAC_BITS);
            nb_l2_next[i] = b0_l1_reg[i] + crd_t'(kv_l1_reg[i] >>> FRAC_BITS);
            dp_l2_next[i] = dif_t'(na_l2_next[i]) - dif_t'(nb_l2_next[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geom_reg[0] <= geom_in;
            for (int i = 1; i < FRONT; i++)
                geom_reg[i] <= geom_reg[i-1];

            // differences a0-b0
            w1_reg[0] <= dif_t'(in_ch.data.a0_x) - dif_t'(in_ch.data.b0_x);
            w1_reg[1] <= dif_t'(in_ch.data.a0_y) - dif_t'(in_ch.data.b0_y);
            w1_reg[2] <= dif_t'(in_ch.data.a0_z) - dif_t'(in_ch.data.b0_z);

            // component products
            for (int i = 0; i < 3; i++)
            begin
                uu2_reg[i] <= prd_t'(geom_reg[0].u[i]) * prd_t'(geom_reg[0].u[i]);
                uv2_reg[i] <= prd_t'(geom_reg[0].u[i]) * prd_t'(geom_reg[0].v[i]);
                vv2_reg[i] <= prd_t'(geom_reg[0].v[i]) * prd_t'(geom_reg[0].v[i]);
                uw2_reg[i] <= prd_t'(geom_reg[0].u[i]) * prd_t'(w1_reg[i]);
                vw2_reg[i] <= prd_t'(geom_reg[0].v[i]) * prd_t'(w1_reg[i]);
            end

            // dot products, floored to q.f
            a3_reg <= dot_t'((sum_t'(uu2_reg[0]) + sum_t'(uu2_reg[1])
                + sum_t'(uu2_reg[2])) >>> FRAC_BITS);
            b3_reg <= dot_t'((sum_t'(uv2_reg[0]) + sum_t'(uv2_reg[1])
                + sum_t'(uv2_reg[2])) >>> FRAC_BITS);
            c3_reg <= dot_t'((sum_t'(vv2_reg[0]) + sum_t'(vv2_reg[1])
                + sum_t'(vv2_reg[2])) >>> FRAC_BITS);
            d3_reg <= dot_t'((sum_t'(uw2_reg[0]) + sum_t'(uw2_reg[1])
                + sum_t'(uw2_reg[2])) >>> FRAC_BITS);
            e3_reg <= dot_t'((sum_t'(vw2_reg[0]) + sum_t'(vw2_reg[1])
                + sum_t'(vw2_reg[2])) >>> FRAC_BITS);

            // wide products in halves
            pac4_reg <= wmul_parts(a3_reg, c3_reg);
            pbb4_reg <= wmul_parts(b3_reg, b3_reg);
            pbe4_reg <= wmul_parts(b3_reg, e3_reg);
            pcd4_reg <= wmul_parts(c3_reg, d3_reg);
            pae4_reg <= wmul_parts(a3_reg, e3_reg);
            pbd4_reg <= wmul_parts(b3_reg, d3_reg);
            a4_reg <= a3_reg;
            b4_reg <= b3_reg;
            c4_reg <= c3_reg;
            d4_reg <= d3_reg;
            e4_reg <= e3_reg;

            pac5_reg <= wmul_sum(pac4_reg);
            pbb5_reg <= wmul_sum(pbb4_reg);
            pbe5_reg <= wmul_sum(pbe4_reg);
            pcd5_reg <= wmul_sum(pcd4_reg);
            pae5_reg <= wmul_sum(pae4_reg);
            pbd5_reg <= wmul_sum(pbd4_reg);
            a5_reg <= a4_reg;
            b5_reg <= b4_reg;
            c5_reg <= c4_reg;
            d5_reg <= d4_reg;
            e5_reg <= e4_reg;

            // determinant and numerators in q.2f, edge numerators in q.f
            det6_reg <= pac5_reg - pbb5_reg;
            sn6_reg  <= pbe5_reg - pcd5_reg;
            tn6_reg  <= pae5_reg - pbd5_reg;
            epb6_reg <= wide_t'(e5_reg) + wide_t'(b5_reg);
            nd6_reg  <= -wide_t'(d5_reg);
            bmd6_reg <= wide_t'(b5_reg) - wide_t'(d5_reg);
            a6_reg   <= wide_t'(a5_reg);
            c6_reg   <= wide_t'(c5_reg);
            e6_reg   <= wide_t'(e5_reg);

            sn7_reg  <= sn7_next;
            sd7_reg  <= sd7_next;
            tn7_reg  <= tn7_next;
            td7_reg  <= td7_next;
            nd7_reg  <= nd6_reg;
            bmd7_reg <= bmd6_reg;
            a7_reg   <= a6_reg;
            nd_neg7_reg   <= nd6_reg < 0;
            a_lt_nd7_reg  <= a6_reg < nd6_reg;
            bmd_neg7_reg  <= bmd6_reg < 0;
            a_lt_bmd7_reg <= a6_reg < bmd6_reg;

            sn8_reg <= sn8_next;
            sd8_reg <= sd8_next;
            tn8_reg <= tn8_next;
            td8_reg <= td8_next;

            sdiv9_reg <= sdiv9_next;
            tdiv9_reg <= tdiv9_next;

            // interpolation products
            s_l1_reg <= s_q;
            t_l1_reg <= t_q;
            for (int i = 0; i < 3; i++)
            begin
                ku_l1_reg[i] <= kp_t'($signed({1'b0, s_q})) * kp_t'(geom_reg[FRONT-1].u[i]);
                kv_l1_reg[i] <= kp_t'($signed({1'b0, t_q})) * kp_t'(geom_reg[FRONT-1].v[i]);
                a0_l1_reg[i] <= geom_reg[FRONT-1].a0[i];
                b0_l1_reg[i] <= geom_reg[FRONT-1].b0[i];
            end

            s_l2_reg <= s_l1_reg;
            t_l2_reg <= t_l1_reg;
            for (int i = 0; i < 3; i++)
            begin
                na_l2_reg[i] <= na_l2_next[i];
                nb_l2_reg[i] <= nb_l2_next[i];
                dp_l2_reg[i] <= dp_l2_next[i];
            end

            // squared separation
            side_l3_reg.s <= s_l2_reg;
            side_l3_reg.t <= t_l2_reg;
            for (int i = 0; i < 3; i++)
            begin
                sqp_l3_reg[i] <= prd_t'(dp_l2_reg[i]) * prd_t'(dp_l2_reg[i]);
                side_l3_reg.na[i] <= na_l2_reg[i];
                side_l3_reg.nb[i] <= nb_l2_reg[i];
            end

            sq_l4_reg <= SQ_W'(sqp_l3_reg[0]) + SQ_W'(sqp_l3_reg[1])
                + SQ_W'(sqp_l3_reg[2]);
            side_l4_reg <= side_l3_reg;

            side_reg[0] <= side_l4_reg;
            for (int i = 1; i < ROOT_W; i++)
                side_reg[i] <= side_reg[i-1];

            out_reg.distance <= DIST_W'(root);
            out_reg.s_param  <= PAR_W'(side_reg[ROOT_W-1].s);
            out_reg.t_param  <= PAR_W'(side_reg[ROOT_W-1].t);
            out_reg.near_a_x <= side_reg[ROOT_W-1].na[0];
            out_reg.near_a_y <= side_reg[ROOT_W-1].na[1];
            out_reg.near_a_z <= side_reg[ROOT_W-1].na[2];
            out_reg.near_b_x <= side_reg[ROOT_W-1].nb[0];
            out_reg.near_b_y <= side_reg[ROOT_W-1].nb[1];
            out_reg.near_b_z <= side_reg[ROOT_W-1].nb[2];
        end
    end

    // parameter dividers, one per segment
    ssd_div u_sdiv (
        .clk (clk),
        .en  (en),
        .din (sdiv9_reg),
        .q   (s_q)
    );

    ssd_div u_tdiv (
        .clk (clk),
        .en  (en),
        .din (tdiv9_reg),
        .q   (t_q)
    );

    // distance root
    ssd_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .sq   (sq_l4_reg),
        .root (root)
    );

endmodule

// File: design/ssd_checker.sv
module ssd_checker
    import ssd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_data
);

    localparam logic [PAR_W-1:0] PAR_ONE = PAR_W'(1) << FRAC_BITS;

    // a held word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    // input side only waits on a stalled output word
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output stall");

    a_s_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.s_param <= PAR_ONE)
        else $error("s parameter above one");

    a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.t_param <= PAR_ONE)
        else $error("t parameter above one");

endmodule

bind segment_segment_distance_3d ssd_checker u_ssd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);
